/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");
// Assert that a condition implies a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");
`endif

/* hw/rtl/blxp_pkg.sv */
// Package with constants and types of the line plotter.
`default_nettype none
package blxp_pkg;
    localparam int ScreenWidth  = 480;
    localparam int ScreenHeight = 240;
    localparam int WordsPerRow  = (ScreenWidth + 31) / 32;
    localparam int FrameDepth   = WordsPerRow * ScreenHeight;
    localparam int AddrW        = $clog2(FrameDepth);
    localparam int WprW         = $clog2(WordsPerRow + 1);

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_INVERT = 2'd2,
        KIND_LINE   = 2'd3
    } kind_t;

    // One queued command.
    typedef struct packed {
        kind_t              kind;
        logic signed [10:0] x0;
        logic signed [10:0] y0;
        logic signed [10:0] x1;
        logic signed [10:0] y1;
        logic               set_bit;
    } cmd_t;

    localparam int CmdW = $bits(cmd_t);
    localparam int QueueDepth = 4;
    localparam int QPtrW = $clog2(QueueDepth);
endpackage
`default_nettype wire

/* hw/rtl/blxp_front.sv */
// Front end: accepts command words, classifies them and feeds the queue.
`default_nettype none
module blxp_front import blxp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                stall_in,
    input  logic [1:0]          kind,
    input  logic signed [10:0]  start_x,
    input  logic signed [10:0]  start_y,
    input  logic signed [10:0]  end_x,
    input  logic signed [10:0]  end_y,
    input  logic [3:0]          color,
    output cmd_t                q_data,
    input  logic                q_pop
);
    cmd_t                 mem_reg [QueueDepth];
    logic [QPtrW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [QPtrW:0]       cnt_reg, cnt_next;
    logic                 push;
    cmd_t                 cmd_in;

    // Classify the incoming word.
    always_comb
    begin
        cmd_in.kind    = kind_t'(kind);
        cmd_in.x0      = start_x;
        cmd_in.y0      = start_y;
        cmd_in.x1      = end_x;
        cmd_in.y1      = end_y;
        cmd_in.set_bit = (color > 4'd7);
    end

    assign stall_in = (cnt_reg == (QPtrW+1)'(QueueDepth));
    assign push     = valid_in && !stall_in;
    assign q_data   = mem_reg[rd_reg];

    // Queue pointers.
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= cmd_in;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/blxp_back.sv */
// Back end: clears the frame buffer, then runs pixel and line commands on it.
`default_nettype none
module blxp_back import blxp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    q_data,
    input  logic    q_valid,
    output logic    q_pop,
    output logic    valid_out,
    input  logic    stall_out,
    output logic    pixel_value
);
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_MOD   = 7'b0001000,
        ST_STEP  = 7'b0010000,
        ST_ERR   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         frame [FrameDepth];
    logic [31:0]         rdata_reg;
    logic [AddrW-1:0]    clr_reg, clr_next;
    kind_t               kind_reg, kind_next;
    logic                set_reg, set_next;
    logic signed [11:0]  x_reg, x_next, y_reg, y_next;
    logic signed [11:0]  x1_reg, x1_next, y1_reg, y1_next;
    logic signed [12:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [13:0]  err_reg, err_next, e2_reg, e2_next;
    logic                sx_reg, sx_next, sy_reg, sy_next;
    logic                val_reg, val_next;
    logic                ovalid_reg, ovalid_next;
    logic [AddrW-1:0]    row_base;
    logic [AddrW-1:0]    addr;
    logic [4:0]          bit_idx;
    logic                on_scr;
    logic                we;
    logic [AddrW-1:0]    waddr;
    logic [31:0]         wdata;
    logic [31:0]         mask;
    logic                done_pt;

    // Address of the current point; the row base is a small multiply.
    assign row_base = AddrW'(y_reg[9:0] * WprW'(WordsPerRow));
    assign addr     = row_base + AddrW'(x_reg[10:5]);
    assign bit_idx  = 5'd31 - x_reg[4:0];
    assign mask     = 32'd1 << bit_idx;
    assign on_scr   = (x_reg >= 0) && (x_reg < 12'(ScreenWidth))
                   && (y_reg >= 0) && (y_reg < 12'(ScreenHeight));
    assign done_pt  = (x_reg == x1_reg) && (y_reg == y1_reg);

    assign valid_out   = ovalid_reg;
    assign pixel_value = val_reg;

    // Command sequencer.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        set_next    = set_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        err_next    = err_reg;
        e2_next     = e2_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        val_next    = val_reg;
        ovalid_next = ovalid_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = addr;
        wdata       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AddrW'(FrameDepth - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_data.kind;
                    set_next  = q_data.set_bit;
                    x_next    = 12'(q_data.x0);
                    y_next    = 12'(q_data.y0);
                    x1_next   = 12'(q_data.x1);
                    y1_next   = 12'(q_data.y1);
                    sx_next   = q_data.x0 < q_data.x1;
                    sy_next   = q_data.y0 < q_data.y1;
                    dx_next   = (q_data.x1 > q_data.x0) ? 13'(q_data.x1) - 13'(q_data.x0)
                                                        : 13'(q_data.x0) - 13'(q_data.x1);
                    dy_next   = (q_data.y1 > q_data.y0) ? 13'(q_data.y0) - 13'(q_data.y1)
                                                        : 13'(q_data.y1) - 13'(q_data.y0);
                    val_next  = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (kind_reg == KIND_LINE)
                begin
                    err_next = 14'(dx_reg) + 14'(dy_reg);
                end
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (on_scr)
                begin
                    unique case (kind_reg)
                        KIND_READ:
                        begin
                            val_next = |(rdata_reg & mask);
                        end
                        KIND_WRITE:
                        begin
                            we    = 1'b1;
                            wdata = set_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
                        end
                        KIND_INVERT:
                        begin
                            we       = 1'b1;
                            wdata    = rdata_reg ^ mask;
                            val_next = |(rdata_reg & mask);
                        end
                        default:
                        begin
                            we    = 1'b1;
                            wdata = rdata_reg ^ mask;
                        end
                    endcase
                end
                if (kind_reg == KIND_LINE && !done_pt)
                begin
                    e2_next    = err_reg <<< 1;
                    state_next = ST_ERR;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_ERR:
            begin
                // One Bresenham step on the doubled error.
                err_next = err_reg
                         + ((e2_reg >= 14'(dy_reg)) ? 14'(dy_reg) : 14'sd0)
                         + ((e2_reg <= 14'(dx_reg)) ? 14'(dx_reg) : 14'sd0);
                if (e2_reg >= 14'(dy_reg))
                begin
                    x_next = sx_reg ? x_reg + 12'sd1 : x_reg - 12'sd1;
                end
                if (e2_reg <= 14'(dx_reg))
                begin
                    y_next = sy_reg ? y_reg + 12'sd1 : y_reg - 12'sd1;
                end
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_MOD;
            end
            ST_OUT:
            begin
                if (!stall_out)
                begin
                    ovalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        set_reg  <= set_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        err_reg  <= err_next;
        e2_reg   <= e2_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        val_reg  <= val_next;
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame[waddr] <= wdata;
        end
        rdata_reg <= frame[addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/bresenham_line_xor_plotter.sv */
// Top level of the line plotter: front end, command queue and back end.
//   channel | direction | words
//   cmd     | in        | kind, start_x, start_y, end_x, end_y, color
//   result  | out       | pixel_value, one word per command
// A pixel command runs the back end through the read, modify and output states; a line
// loops through the modify, error and step states per point, a read-modify-write on the frame memory.
// A result waiting on stall_out holds the back end until it is taken.
// After reset the back end clears all 3600 words of the frame memory before
// running commands; up to four commands queue meanwhile.
// Input stall rises only when the four-entry queue is full.
`default_nettype none
module bresenham_line_xor_plotter import blxp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               stall_in,
    input  logic [1:0]         kind,
    input  logic signed [10:0] start_x,
    input  logic signed [10:0] start_y,
    input  logic signed [10:0] end_x,
    input  logic signed [10:0] end_y,
    input  logic [3:0]         color,
    output logic               valid_out,
    input  logic               stall_out,
    output logic               pixel_value
);
    cmd_t   q_data;
    logic   q_valid;
    logic   q_pop;
    logic   u_front_nonempty;

    blxp_front u_front (
        .clk, .rst_n, .valid_in, .stall_in, .kind, .start_x, .start_y,
        .end_x, .end_y, .color, .q_data, .q_pop
    );

    // Queue holds a word whenever its count is nonzero.
    assign q_valid = u_front_nonempty;
    blxp_qstat u_qstat (.clk, .rst_n, .push(valid_in && !stall_in), .pop(q_pop),
                        .nonempty(u_front_nonempty));

    blxp_back u_back (
        .clk, .rst_n, .q_data, .q_valid, .q_pop, .valid_out, .stall_out,
        .pixel_value
    );
endmodule
`default_nettype wire

/* hw/rtl/blxp_qstat.sv */
// Occupancy tracker mirroring the command queue fill level.
`default_nettype none
module blxp_qstat import blxp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic pop,
    output logic nonempty
);
    logic [QPtrW:0] cnt_reg, cnt_next;

    assign cnt_next = cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    assign nonempty = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/blxp_checker.sv */
// Port-level checker for the line plotter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module blxp_checker (
    input logic clk,
    input logic rst_n,
    input logic valid_in,
    input logic stall_in,
    input logic valid_out,
    input logic stall_out,
    input logic pixel_value
);
    `CHK_NEXT(a_out_hold, clk, rst_n, valid_out && stall_out, valid_out)
    `CHK_NEXT(a_val_hold, clk, rst_n, valid_out && stall_out, $stable(pixel_value))
    `CHK_NEXT(a_out_gap, clk, rst_n, valid_out && !stall_out, !valid_out)
    `CHK_IMPL(a_no_x_out, clk, rst_n, valid_out, !$isunknown(pixel_value))
    `CHK_IMPL(a_no_x_stall, clk, rst_n, valid_in, !$isunknown(stall_in))
endmodule

bind bresenham_line_xor_plotter blxp_checker u_blxp_checker (
    .clk, .rst_n, .valid_in, .stall_in, .valid_out, .stall_out, .pixel_value
);
`default_nettype wire
